FILE: design/gh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gh_pkg;

  // Field element width; bit 127 of a packed element is the x^0 coefficient.
  localparam int unsigned GH_W = 128;
  localparam int unsigned HALF_W = 64;

  // Multiplier digit: key bits consumed per cycle of the back end when not held.
  localparam int unsigned DIGIT_BITS = 8;
  localparam int unsigned STEPS = GH_W / DIGIT_BITS;
  localparam int unsigned STEP_W = $clog2(STEPS);

  // Reduction byte folded into the x^0..x^7 end on a carry out of x^127.
  localparam logic [7:0] GH_REDUCE = 8'hE1;

  // Job queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [HALF_W-1:0] blk_hi;
    logic [HALF_W-1:0] blk_lo;
    logic              first;
    logic              last;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } fr_stat_t;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
  } bk_stat_t;

endpackage

`default_nettype wire

FILE: design/gh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gh_front import gh_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output      logic                s_ready_o,
  input  wire logic [2*HALF_W-1:0] s_data_i,   // [63:0] block_hi, [127:64] block_lo
  input  wire logic                s_user_i,   // first
  input  wire logic                s_last_i,
  output      logic                job_valid_o,
  input  wire logic                job_ready_i,
  output      job_t                job_o,
  output      fr_stat_t            stat_o
);

  job_t              q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  job_t              job_in;
  logic              push, pop;

  // Split the beat into a job entry.
  always_comb begin
    job_in.blk_hi = s_data_i[HALF_W-1:0];
    job_in.blk_lo = s_data_i[2*HALF_W-1:HALF_W];
    job_in.first  = s_user_i;
    job_in.last   = s_last_i;
  end

  assign s_ready_o   = (cnt_q != QCNT_W'(QDEPTH));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;

  assign push = s_valid_i && s_ready_o;
  assign pop  = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/gh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gh_back import gh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [HALF_W-1:0] key_hi_i,
  input  wire logic [HALF_W-1:0] key_lo_i,
  input  wire logic              job_valid_i,
  output      logic              job_ready_o,
  input  wire job_t              job_i,
  output      logic              m_valid_o,
  input  wire logic              m_ready_i,
  output      logic [HALF_W-1:0] tag_hi_o,
  output      logic [HALF_W-1:0] tag_lo_o,
  output      bk_stat_t          stat_o
);

  logic [GH_W-1:0]   acc_q;
  logic [GH_W-1:0]   r_q, v_q, h_q;
  logic [GH_W-1:0]   r_n, v_n;
  logic [GH_W-1:0]   acc_base, x_in;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, last_q;
  logic              out_valid_q;
  logic [GH_W-1:0]   out_data_q;
  logic              final_step, hold, done, start;

  // One digit of the shift-and-add multiply: walk DIGIT_BITS key bits,
  // x^0 first, stepping V by x each bit.
  always_comb begin
    logic c;
    r_n = r_q;
    v_n = v_q;
    c   = 1'b0;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (h_q[GH_W-1-j]) begin
        r_n = r_n ^ v_n;
      end
      c   = v_n[0];
      v_n = v_n >> 1;
      if (c) begin
        v_n[GH_W-1 -: 8] = v_n[GH_W-1 -: 8] ^ GH_REDUCE;
      end
    end
  end

  assign final_step = (cnt_q == STEP_W'(STEPS - 1));
  // A tag cannot retire while the previous one still sits unclaimed.
  assign hold       = last_q && out_valid_q && !m_ready_i;
  assign done       = busy_q && final_step && !hold;
  assign job_ready_o = !busy_q || done;
  assign start      = job_valid_i && job_ready_o;

  // Forward the retiring product so the next job starts without a bubble.
  assign acc_base = done ? r_n : acc_q;
  assign x_in     = (job_i.first ? '0 : acc_base) ^ {job_i.blk_hi, job_i.blk_lo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && !final_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (done) begin
        acc_q <= r_n;
      end
      if (done && last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      v_q    <= x_in;
      r_q    <= '0;
      h_q    <= {key_hi_i, key_lo_i};
      last_q <= job_i.last;
    end else if (busy_q && !final_step) begin
      r_q <= r_n;
      v_q <= v_n;
      h_q <= h_q << DIGIT_BITS;
    end
    if (done && last_q) begin
      out_data_q <= r_n;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign tag_hi_o    = out_data_q[GH_W-1:HALF_W];
  assign tag_lo_o    = out_data_q[HALF_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.step = cnt_q;

endmodule

`default_nettype wire

FILE: design/ghash_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// GHASH accumulator for GCM: each item carries one 128-bit block; the block is
// XORed into a running accumulator (cleared first when tuser/first is set) and
// the sum is multiplied by the hash key H in GF(2^128), GCM bit-reflected
// order. An item with tlast set produces one result, the updated accumulator,
// as the tag; the chain is not cleared after a tag. Each item occupies the
// multiplier over its 128 key bits, 8 per cycle unless a waiting tag holds the
// final step; the next item starts in the cycle the previous one retires. A
// 2-entry input queue takes items while the multiplier works, dropping tready
// only when full, and a registered output slot lets the multiplier run on
// while a tag waits to be taken. H is written through the APB port (key_hi at
// 0x0, key_lo at 0x8, 64-bit data); write it only while the block is idle, as
// the block itself does not enforce this. Both halves reset to zero.
module ghash_accumulator import gh_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // APB configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [HALF_W-1:0]   pwdata,
  output      logic [HALF_W-1:0]   prdata,
  output      logic                pready,
  // block input
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [2*HALF_W-1:0] s_axis_tdata,  // [63:0] block_hi, [127:64] block_lo
  input  wire logic                s_axis_tuser,  // [0] first
  input  wire logic                s_axis_tlast,  // last
  // tag output
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [2*HALF_W-1:0] m_axis_tdata   // [63:0] tag_hi, [127:64] tag_lo
);

  // Register index lives in paddr[3]; lower bits pick byte lanes and are ignored.
  localparam logic REG_KEY_HI = 1'b0;
  localparam logic REG_KEY_LO = 1'b1;

  logic [HALF_W-1:0] key_hi_q, key_lo_q;
  logic              cfg_wr;
  logic              job_valid, job_ready;
  job_t              job;
  fr_stat_t          fr_stat;
  bk_stat_t          bk_stat;
  logic [HALF_W-1:0] tag_hi, tag_lo;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_KEY_HI: key_hi_q <= pwdata;
        REG_KEY_LO: key_lo_q <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_KEY_HI: prdata = key_hi_q;
      REG_KEY_LO: prdata = key_lo_q;
      default:    prdata = '0;
    endcase
  end

  // ---- front: accept and queue items ----
  gh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .s_last_i    (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job),
    .stat_o      (fr_stat)
  );

  // ---- back: digit-serial GF(2^128) multiply and tag register ----
  gh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_hi_i    (key_hi_q),
    .key_lo_i    (key_lo_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .tag_hi_o    (tag_hi),
    .tag_lo_o    (tag_lo),
    .stat_o      (bk_stat)
  );

  assign m_axis_tdata = {tag_lo, tag_hi};

  // ---- assertions ----
  // tready drops only when the queue is full.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (fr_stat.count == QCNT_W'(QDEPTH)))
    else $error("input stalled with queue not full");

  // Queue occupancy never exceeds its depth.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue overflow");

  // The multiply runs its digits without gaps.
  a_step_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.busy && (bk_stat.step != STEP_W'(STEPS - 1))) |=>
      (bk_stat.busy && (bk_stat.step == STEP_W'($past(bk_stat.step) + 1'b1))))
    else $error("multiply step skipped or stalled");

  // A tag only appears out of a running multiply.
  a_tag_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(bk_stat.busy))
    else $error("tag without a multiply");

endmodule

`default_nettype wire
